### hw/rtl/bdrf_pkg.sv
package bdrf_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned LbaW = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned NumBlkW = 64;
  localparam int unsigned IdW = 32;
  localparam int unsigned DataW = 64;
  localparam int unsigned OffsetW = 8;
  localparam int unsigned SizeW = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 8;

  // Register window offsets.
  localparam logic [OffsetW-1:0] OFF_MAGIC   = 8'h00;
  localparam logic [OffsetW-1:0] OFF_VERSION = 8'h04;
  localparam logic [OffsetW-1:0] OFF_BSIZE   = 8'h08;
  localparam logic [OffsetW-1:0] OFF_FEAT    = 8'h0C;
  localparam logic [OffsetW-1:0] OFF_NBLK    = 8'h10;
  localparam logic [OffsetW-1:0] OFF_BUF     = 8'h18;
  localparam logic [OffsetW-1:0] OFF_LBA     = 8'h20;
  localparam logic [OffsetW-1:0] OFF_CNT     = 8'h28;
  localparam logic [OffsetW-1:0] OFF_STAT    = 8'h2C;
  localparam logic [OffsetW-1:0] OFF_CMD     = 8'h30;

  localparam logic [SizeW-1:0] SIZE_WORD  = 4'd4;
  localparam logic [SizeW-1:0] SIZE_DWORD = 4'd8;

  localparam logic [31:0] CMD_TO_MEM   = 32'd1;
  localparam logic [31:0] CMD_TO_IMAGE = 32'd2;

  localparam logic [IdW-1:0] BSIZE_RESET = 32'd512;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAGIC   = 8'd0,
    CFG_VERSION = 8'd1,
    CFG_BSIZE   = 8'd2,
    CFG_FEAT    = 8'd3,
    CFG_NBLK    = 8'd4
  } cfg_idx_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 3'd0,
    ST_BADCMD = 3'd1,
    ST_COUNT  = 3'd2,
    ST_RANGE  = 3'd3,
    ST_BUFFER = 3'd4
  } status_t;

  typedef struct packed {
    logic [IdW-1:0]     magic_id;
    logic [IdW-1:0]     version_id;
    logic [IdW-1:0]     block_bytes;
    logic [IdW-1:0]     feature_bits;
    logic [NumBlkW-1:0] image_blocks;
    logic [AddrW-1:0]   buffer_address;
    logic [LbaW-1:0]    start_block;
    logic [CountW-1:0]  block_count;
    status_t            status_code;
  } state_t;

  typedef struct packed {
    logic    buf_we;
    logic    lba_we;
    logic    cnt_we;
    logic    stat_we;
    status_t stat_val;
  } upd_t;

  typedef struct packed {
    logic               op;
    logic [OffsetW-1:0] offset;
    logic [SizeW-1:0]   access_size;
    logic [DataW-1:0]   write_value;
    logic               buffer_ok;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0]  read_data;
    logic              xfer_start;
    logic              xfer_dir;
    logic [AddrW-1:0]  xfer_addr;
    logic [LbaW-1:0]   xfer_lba;
    logic [CountW-1:0] xfer_blocks;
  } res_t;

endpackage

### hw/rtl/block_device_register_front_unit.sv
// Register front end of a block storage device. Each bus access word enters an
// input register, is decoded and executed against the register file once the
// output register is free, and its result word (read data and any transfer
// request for an external DMA engine) is held in that output register until
// taken. One word is accepted every cycle while the output side keeps up; the
// result passes from the input register through the single decode and command
// check stage into the output register.
module block_device_register_front_unit
  import bdrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [OffsetW-1:0] offset,
  input  logic [SizeW-1:0]   access_size,
  input  logic [DataW-1:0]   write_value,
  input  logic               buffer_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DataW-1:0]   read_data,
  output logic               xfer_start,
  output logic               xfer_dir,
  output logic [AddrW-1:0]   xfer_addr,
  output logic [LbaW-1:0]    xfer_lba,
  output logic [CountW-1:0]  xfer_blocks
);

  logic   req_valid;
  req_t   req;
  res_t   res;
  res_t   res_next;
  upd_t   upd;
  state_t st;
  logic   advance;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) req_valid <= in_valid;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.op          <= op;
      req.offset      <= offset;
      req.access_size <= access_size;
      req.write_value <= write_value;
      req.buffer_ok   <= buffer_ok;
    end
    if (advance) res <= res_next;
  end

  bdrf_exec u_exec (
    .req (req),
    .st  (st),
    .upd (upd),
    .res (res_next)
  );

  bdrf_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .commit    (advance),
    .upd       (upd),
    .wdata     (req.write_value),
    .st        (st)
  );

  assign read_data   = res.read_data;
  assign xfer_start  = res.xfer_start;
  assign xfer_dir    = res.xfer_dir;
  assign xfer_addr   = res.xfer_addr;
  assign xfer_lba    = res.xfer_lba;
  assign xfer_blocks = res.xfer_blocks;

endmodule

### hw/rtl/bdrf_exec.sv
module bdrf_exec
  import bdrf_pkg::*;
(
  input  req_t   req,
  input  state_t st,
  output upd_t   upd,
  output res_t   res
);

  logic        hit_magic, hit_version, hit_bsize, hit_feat, hit_nblk;
  logic        hit_buf, hit_lba, hit_cnt, hit_stat, hit_cmd;
  logic [31:0] cmd;
  logic        cmd_ok;
  logic        range_bad;
  logic        go;
  logic        wr;
  status_t     cmd_status;

  assign hit_magic   = req.offset == OFF_MAGIC   && req.access_size == SIZE_WORD;
  assign hit_version = req.offset == OFF_VERSION && req.access_size == SIZE_WORD;
  assign hit_bsize   = req.offset == OFF_BSIZE   && req.access_size == SIZE_WORD;
  assign hit_feat    = req.offset == OFF_FEAT    && req.access_size == SIZE_WORD;
  assign hit_nblk    = req.offset == OFF_NBLK    && req.access_size == SIZE_DWORD;
  assign hit_buf     = req.offset == OFF_BUF     && req.access_size == SIZE_DWORD;
  assign hit_lba     = req.offset == OFF_LBA     && req.access_size == SIZE_DWORD;
  assign hit_cnt     = req.offset == OFF_CNT     && req.access_size == SIZE_WORD;
  assign hit_stat    = req.offset == OFF_STAT    && req.access_size == SIZE_WORD;
  assign hit_cmd     = req.offset == OFF_CMD     && req.access_size == SIZE_WORD;

  assign wr = req.op;
  assign cmd = req.write_value[31:0];
  assign cmd_ok = cmd == CMD_TO_MEM || cmd == CMD_TO_IMAGE;
  assign range_bad = (st.start_block >= st.image_blocks) ||
                     ({32'd0, st.block_count} > (st.image_blocks - st.start_block));

  always_comb begin
    if (!cmd_ok) begin
      cmd_status = ST_BADCMD;
    end else if (st.block_count == '0) begin
      cmd_status = ST_COUNT;
    end else if (range_bad) begin
      cmd_status = ST_RANGE;
    end else if (!req.buffer_ok) begin
      cmd_status = ST_BUFFER;
    end else begin
      cmd_status = ST_OK;
    end
  end

  assign go = wr && hit_cmd && cmd_ok && cmd_status == ST_OK;

  always_comb begin
    upd.buf_we   = wr && hit_buf;
    upd.lba_we   = wr && hit_lba;
    upd.cnt_we   = wr && hit_cnt;
    upd.stat_we  = wr && (hit_stat || hit_cmd);
    upd.stat_val = hit_cmd ? cmd_status : ST_OK;
  end

  always_comb begin
    res.read_data = '0;
    if (!wr) begin
      if (hit_magic) begin
        res.read_data = {32'd0, st.magic_id};
      end else if (hit_version) begin
        res.read_data = {32'd0, st.version_id};
      end else if (hit_bsize) begin
        res.read_data = {32'd0, st.block_bytes};
      end else if (hit_feat) begin
        res.read_data = {32'd0, st.feature_bits};
      end else if (hit_nblk) begin
        res.read_data = st.image_blocks;
      end else if (hit_buf) begin
        res.read_data = st.buffer_address;
      end else if (hit_lba) begin
        res.read_data = st.start_block;
      end else if (hit_cnt) begin
        res.read_data = {32'd0, st.block_count};
      end else if (hit_stat) begin
        res.read_data = {61'd0, st.status_code};
      end
    end
    res.xfer_start  = go;
    res.xfer_dir    = go && cmd == CMD_TO_IMAGE;
    res.xfer_addr   = go ? st.buffer_address : '0;
    res.xfer_lba    = go ? st.start_block : '0;
    res.xfer_blocks = go ? st.block_count : '0;
  end

endmodule

### hw/rtl/bdrf_regs.sv
module bdrf_regs
  import bdrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data,
  input  logic               commit,
  input  upd_t               upd,
  input  logic [DataW-1:0]   wdata,
  output state_t             st
);

  always_ff @(posedge clk) begin
    if (rst) begin
      st.magic_id       <= '0;
      st.version_id     <= '0;
      st.block_bytes    <= BSIZE_RESET;
      st.feature_bits   <= '0;
      st.image_blocks   <= '0;
      st.buffer_address <= '0;
      st.start_block    <= '0;
      st.block_count    <= '0;
      st.status_code    <= ST_OK;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_MAGIC:   st.magic_id     <= cfg_data[IdW-1:0];
          CFG_VERSION: st.version_id   <= cfg_data[IdW-1:0];
          CFG_BSIZE:   st.block_bytes  <= cfg_data[IdW-1:0];
          CFG_FEAT:    st.feature_bits <= cfg_data[IdW-1:0];
          CFG_NBLK:    st.image_blocks <= cfg_data;
          default: ;
        endcase
      end
      if (commit) begin
        if (upd.buf_we) st.buffer_address <= wdata;
        if (upd.lba_we) st.start_block <= wdata;
        if (upd.cnt_we) st.block_count <= wdata[CountW-1:0];
        if (upd.stat_we) st.status_code <= upd.stat_val;
      end
    end
  end

endmodule

### test/testbench.sv
module testbench;
  import bdrf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [DataW-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               op = 1'b0;
  logic [OffsetW-1:0] offset = '0;
  logic [SizeW-1:0]   access_size = '0;
  logic [DataW-1:0]   write_value = '0;
  logic               buffer_ok = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [DataW-1:0]   read_data;
  logic               xfer_start;
  logic               xfer_dir;
  logic [AddrW-1:0]   xfer_addr;
  logic [LbaW-1:0]    xfer_lba;
  logic [CountW-1:0]  xfer_blocks;

  block_device_register_front_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .offset(offset),
    .access_size(access_size),
    .write_value(write_value),
    .buffer_ok(buffer_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .xfer_start(xfer_start),
    .xfer_dir(xfer_dir),
    .xfer_addr(xfer_addr),
    .xfer_lba(xfer_lba),
    .xfer_blocks(xfer_blocks)
  );

  // Shadow copy of the identification words and the device registers.
  logic [IdW-1:0]     id_magic = '0;
  logic [IdW-1:0]     id_version = '0;
  logic [IdW-1:0]     id_block_bytes = BSIZE_RESET;
  logic [IdW-1:0]     id_features = '0;
  logic [NumBlkW-1:0] id_image_blocks = '0;
  logic [AddrW-1:0]   regs_buf_addr = '0;
  logic [LbaW-1:0]    regs_start_blk = '0;
  logic [CountW-1:0]  regs_blk_cnt = '0;
  status_t            regs_status = ST_OK;

  res_t pending_results[$];
  int   mismatches = 0;
  int   items_sent = 0;
  int   cycle_count = 0;
  bit   tx_idle_on = 1'b1;
  bit   rx_idle_on = 1'b1;
  int   rx_hold_len = 0;

  logic [OffsetW-1:0] reg_offsets[10] = '{OFF_MAGIC, OFF_VERSION, OFF_BSIZE, OFF_FEAT,
                                         OFF_NBLK, OFF_BUF, OFF_LBA, OFF_CNT, OFF_STAT,
                                         OFF_CMD};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Applies one bus access to the shadow registers and returns the result word.
  function automatic res_t decode_access(logic is_wr, logic [OffsetW-1:0] off,
                                         logic [SizeW-1:0] sz, logic [DataW-1:0] val,
                                         logic bok);
    res_t        r;
    logic [31:0] code;
    r = '0;
    if (!is_wr) begin
      if (sz == SIZE_WORD) begin
        case (off)
          OFF_MAGIC:   r.read_data = 64'(id_magic);
          OFF_VERSION: r.read_data = 64'(id_version);
          OFF_BSIZE:   r.read_data = 64'(id_block_bytes);
          OFF_FEAT:    r.read_data = 64'(id_features);
          OFF_CNT:     r.read_data = 64'(regs_blk_cnt);
          OFF_STAT:    r.read_data = 64'(regs_status);
          default:     r.read_data = '0;
        endcase
      end else if (sz == SIZE_DWORD) begin
        case (off)
          OFF_NBLK: r.read_data = id_image_blocks;
          OFF_BUF:  r.read_data = regs_buf_addr;
          OFF_LBA:  r.read_data = regs_start_blk;
          default:  r.read_data = '0;
        endcase
      end
    end else if (sz == SIZE_DWORD && off == OFF_BUF) begin
      regs_buf_addr = val;
    end else if (sz == SIZE_DWORD && off == OFF_LBA) begin
      regs_start_blk = val;
    end else if (sz == SIZE_WORD && off == OFF_CNT) begin
      regs_blk_cnt = val[31:0];
    end else if (sz == SIZE_WORD && off == OFF_STAT) begin
      regs_status = ST_OK;
    end else if (sz == SIZE_WORD && off == OFF_CMD) begin
      code = val[31:0];
      regs_status = ST_OK;
      if (code != CMD_TO_MEM && code != CMD_TO_IMAGE) begin
        regs_status = ST_BADCMD;
      end else if (regs_blk_cnt == '0) begin
        regs_status = ST_COUNT;
      end else if (regs_start_blk >= id_image_blocks ||
                   64'(regs_blk_cnt) > id_image_blocks - regs_start_blk) begin
        regs_status = ST_RANGE;
      end else if (!bok) begin
        regs_status = ST_BUFFER;
      end else begin
        r.xfer_start = 1'b1;
        r.xfer_dir = (code == CMD_TO_IMAGE);
        r.xfer_addr = regs_buf_addr;
        r.xfer_lba = regs_start_blk;
        r.xfer_blocks = regs_blk_cnt;
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    $display("mismatch in %s at cycle %0d: got %h, expected %h", what, cycle_count, got,
             want);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result word", read_data, '0);
      end else begin
        want = pending_results.pop_front();
        if (read_data !== want.read_data) report("read_data", read_data, want.read_data);
        if (xfer_start !== want.xfer_start) report("xfer_start", xfer_start, want.xfer_start);
        if (xfer_dir !== want.xfer_dir) report("xfer_dir", xfer_dir, want.xfer_dir);
        if (xfer_addr !== want.xfer_addr) report("xfer_addr", xfer_addr, want.xfer_addr);
        if (xfer_lba !== want.xfer_lba) report("xfer_lba", xfer_lba, want.xfer_lba);
        if (xfer_blocks !== want.xfer_blocks) begin
          report("xfer_blocks", xfer_blocks, want.xfer_blocks);
        end
      end
    end
  end

  // Result side: random stalls, or one long hold when requested.
  initial begin
    int n;
    forever begin
      if (rx_hold_len > 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 10);
        out_ready <= 1'b0;
      end else begin
        n = $urandom_range(1, 10);
        out_ready <= 1'b1;
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_access(input logic is_wr, input logic [OffsetW-1:0] off,
                             input logic [SizeW-1:0] sz, input logic [DataW-1:0] val,
                             input logic bok);
    in_valid <= 1'b1;
    op <= is_wr;
    offset <= off;
    access_size <= sz;
    write_value <= val;
    buffer_ok <= bok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(decode_access(is_wr, off, sz, val, bok));
    items_sent++;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic reg_read(input logic [OffsetW-1:0] off, input logic [SizeW-1:0] sz);
    send_access(1'b0, off, sz, rand64(), 1'($urandom_range(0, 1)));
  endtask

  task automatic reg_write(input logic [OffsetW-1:0] off, input logic [SizeW-1:0] sz,
                           input logic [DataW-1:0] val, input logic bok);
    send_access(1'b1, off, sz, val, bok);
  endtask

  task automatic random_access();
    if ($urandom_range(0, 1)) begin
      send_access(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  4'($urandom_range(0, 15)), rand64(), 1'($urandom_range(0, 1)));
    end else begin
      send_access(1'($urandom_range(0, 1)), reg_offsets[$urandom_range(0, 9)],
                  $urandom_range(0, 1) ? SIZE_WORD : SIZE_DWORD, rand64(),
                  1'($urandom_range(0, 1)));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [DataW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MAGIC:   id_magic = val[31:0];
      CFG_VERSION: id_version = val[31:0];
      CFG_BSIZE:   id_block_bytes = val[31:0];
      CFG_FEAT:    id_features = val[31:0];
      CFG_NBLK:    id_image_blocks = val;
      default:     ;
    endcase
  endtask

  task automatic load_settings(input logic [DataW-1:0] magic, input logic [DataW-1:0] version,
                               input logic [DataW-1:0] bsize, input logic [DataW-1:0] feat,
                               input logic [DataW-1:0] nblk);
    write_cfg(CFG_MAGIC, magic);
    write_cfg(CFG_VERSION, version);
    write_cfg(CFG_BSIZE, bsize);
    write_cfg(CFG_FEAT, feat);
    write_cfg(CFG_NBLK, nblk);
  endtask

  task automatic test_reset_values();
    foreach (reg_offsets[i]) begin
      reg_read(reg_offsets[i], (reg_offsets[i] == OFF_NBLK || reg_offsets[i] == OFF_BUF ||
                                reg_offsets[i] == OFF_LBA) ? SIZE_DWORD : SIZE_WORD);
    end
    reg_read(OFF_BSIZE, SIZE_DWORD);
    reg_read(8'hFF, 4'hF);
    reg_write(OFF_BSIZE, SIZE_WORD, '1, 1'b1);
    reg_read(OFF_BSIZE, SIZE_WORD);
  endtask

  task automatic test_command_checks();
    settle();
    load_settings(rand64(), rand64(), 64'd4096, rand64(), 64'd100);
    reg_write(OFF_CNT, SIZE_WORD, 64'hFFFF_FFFF_0000_0000, 1'b1);
    reg_write(OFF_CMD, SIZE_WORD, 64'(CMD_TO_MEM), 1'b1);
    reg_read(OFF_STAT, SIZE_WORD);
    reg_write(OFF_LBA, SIZE_DWORD, 64'd100, 1'b1);
    reg_write(OFF_CNT, SIZE_WORD, 64'd1, 1'b1);
    reg_write(OFF_CMD, SIZE_WORD, 64'(CMD_TO_IMAGE), 1'b1);
    reg_write(OFF_LBA, SIZE_DWORD, 64'd95, 1'b1);
    reg_write(OFF_CNT, SIZE_WORD, 64'd6, 1'b1);
    reg_write(OFF_CMD, SIZE_WORD, 64'(CMD_TO_MEM), 1'b1);
    reg_write(OFF_CNT, SIZE_WORD, 64'd5, 1'b1);
    reg_write(OFF_CMD, SIZE_WORD, 64'(CMD_TO_MEM), 1'b0);
    reg_read(OFF_STAT, SIZE_WORD);
    reg_write(OFF_STAT, SIZE_WORD, '1, 1'b0);
    reg_read(OFF_STAT, SIZE_WORD);
    reg_write(OFF_BUF, SIZE_DWORD, '1, 1'b0);
    reg_write(OFF_CMD, SIZE_WORD, {32'hFFFF_FFFF, CMD_TO_MEM}, 1'b1);
    reg_write(OFF_CMD, SIZE_WORD, 64'(CMD_TO_IMAGE), 1'b1);
    reg_write(OFF_CMD, SIZE_WORD, 64'd3, 1'b1);
    reg_read(OFF_STAT, SIZE_WORD);
    reg_write(OFF_NBLK, SIZE_DWORD, '0, 1'b1);
    reg_read(OFF_NBLK, SIZE_DWORD);
  endtask

  // Mostly complete transfer setups with boundary-heavy ranges, mixed with stray accesses.
  task automatic test_random_traffic();
    logic [LbaW-1:0]   lba;
    logic [LbaW-1:0]   room;
    logic [CountW-1:0] cnt;
    logic [31:0]       code;
    int                target;
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0:       load_settings('0, '0, 64'd1, '0, '0);
        1:       load_settings('1, '1, '1, '1, '1);
        2:       load_settings(rand64(), rand64(), 64'($urandom_range(1, 32'hFFFF_FFFF)),
                               rand64(), 64'd1);
        3:       load_settings(rand64(), rand64(), 64'd512, rand64(),
                               64'($urandom_range(1, 1000)));
        default: load_settings(rand64(), rand64(), 64'($urandom_range(1, 32'hFFFF_FFFF)),
                               rand64(), rand64());
      endcase
      target = items_sent + 84;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 1)) reg_write(OFF_BUF, SIZE_DWORD, rand64(), 1'b1);
          case ($urandom_range(0, 3))
            0:       lba = 64'($urandom_range(0, 8));
            1:       lba = id_image_blocks - 64'($urandom_range(0, 8));
            2:       lba = rand64();
            default: lba = id_image_blocks + 64'($urandom_range(0, 2));
          endcase
          room = id_image_blocks - lba;
          case ($urandom_range(0, 3))
            0:       cnt = $urandom_range(0, 8);
            1:       cnt = room[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
            2:       cnt = $urandom;
            default: cnt = room[31:0];
          endcase
          case ($urandom_range(0, 5))
            0:       code = $urandom;
            1:       code = $urandom_range(0, 4);
            2, 3:    code = CMD_TO_MEM;
            default: code = CMD_TO_IMAGE;
          endcase
          reg_write(OFF_LBA, SIZE_DWORD, lba, 1'($urandom_range(0, 1)));
          reg_write(OFF_CNT, SIZE_WORD, {$urandom, cnt}, 1'($urandom_range(0, 1)));
          reg_write(OFF_CMD, SIZE_WORD, {$urandom, code}, 1'($urandom_range(0, 4) != 0));
          if ($urandom_range(0, 1)) reg_read(OFF_STAT, SIZE_WORD);
          if ($urandom_range(0, 3) == 0) reg_write(OFF_STAT, SIZE_WORD, rand64(), 1'b1);
        end else begin
          random_access();
        end
      end
    end
  endtask

  task automatic test_backpressure();
    settle();
    tx_idle_on = 1'b0;
    rx_hold_len = 60;
    repeat (30) random_access();
    tx_idle_on = 1'b1;
    settle();
  endtask

  task automatic test_closing_burst();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (40) random_access();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_command_checks();
    test_random_traffic();
    test_backpressure();
    test_closing_burst();
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
